### src/gravity_align_quaternion_core_defines.svh
// ----------------------------------------------------------------------------
// gravity align quaternion core assertion macros
// checks are compiled in unless SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef GRAVITY_ALIGN_QUATERNION_CORE_DEFINES_SVH
`define GRAVITY_ALIGN_QUATERNION_CORE_DEFINES_SVH
`ifndef SYNTH
`define GAQ_ASSERT_IMP(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("gaq: same-cycle check failed");
`define GAQ_ASSERT_NXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("gaq: next-cycle check failed");
`else
`define GAQ_ASSERT_IMP(lbl, clk, rst_n, pre, post)
`define GAQ_ASSERT_NXT(lbl, clk, rst_n, pre, post)
`endif
`endif

### src/gaq_pkg.sv
// ----------------------------------------------------------------------------
// gaq_pkg
// widths and constants of the gravity align quaternion core
// ----------------------------------------------------------------------------
package gaq_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int QUAT_FRAC_BITS = 14;
    localparam int QUAT_BITS      = QUAT_FRAC_BITS + 2;
    localparam int PRE_BITS       = 21;
    localparam int VEC_BITS       = 30;
    localparam int N_FRAC         = 8;
    localparam int LANES          = 3;

    localparam int MAG_W  = SAMPLE_BITS;
    localparam int BL1_W  = $clog2(MAG_W + 1);
    localparam int SQR1_W = 2 * PRE_BITS;
    localparam int SUM1_W = 2 * PRE_BITS + 2;
    localparam int V_W    = PRE_BITS + N_FRAC + 2;
    localparam int BL2_W  = $clog2(V_W + 1);
    localparam int SQR2_W = 2 * VEC_BITS;
    localparam int SUM2_W = 2 * VEC_BITS + 2;

    localparam int RAD_MIN  = (SUM2_W > SUM1_W + 2 * N_FRAC) ? SUM2_W : SUM1_W + 2 * N_FRAC;
    localparam int SQ_STEPS = (RAD_MIN + 1) / 2;
    localparam int RAD_W    = 2 * SQ_STEPS;
    localparam int ROOT_W   = SQ_STEPS;
    localparam int REM_W    = SQ_STEPS + 2;

    localparam int DIV_STEPS = QUAT_FRAC_BITS + 1;
    localparam int QUO_W     = DIV_STEPS;
    localparam int DSH_W     = ROOT_W + QUAT_FRAC_BITS;
    localparam int DREM_W    = DSH_W + 1;

    // register stages from the input to the output register
    localparam int PIPE_LAT = 12 + 2 * SQ_STEPS + DIV_STEPS;

    localparam logic signed [QUAT_BITS-1:0] QUAT_ONE = QUAT_BITS'(1 << QUAT_FRAC_BITS);

endpackage

### src/gaq_sqrt_cell.sv
// ----------------------------------------------------------------------------
// gaq_sqrt_cell
// one radix-2 step of a restoring integer square root, registered
// ----------------------------------------------------------------------------
module gaq_sqrt_cell (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [gaq_pkg::RAD_W-1:0]  i_rad,
    input  logic [gaq_pkg::REM_W-1:0]  i_rem,
    input  logic [gaq_pkg::ROOT_W-1:0] i_root,
    output logic [gaq_pkg::RAD_W-1:0]  o_rad,
    output logic [gaq_pkg::REM_W-1:0]  o_rem,
    output logic [gaq_pkg::ROOT_W-1:0] o_root
);

    logic [gaq_pkg::RAD_W-1:0]  r_rad,  n_rad;
    logic [gaq_pkg::REM_W-1:0]  r_rem,  n_rem;
    logic [gaq_pkg::ROOT_W-1:0] r_root, n_root;
    logic [gaq_pkg::REM_W+1:0]  w_acc;
    logic [gaq_pkg::REM_W+1:0]  w_trial;
    logic [gaq_pkg::REM_W+1:0]  w_diff;
    logic                       w_ge;

    always_comb begin
        // bring down the next two radicand bits
        w_acc   = {i_rem, i_rad[gaq_pkg::RAD_W-1 -: 2]};
        w_trial = (gaq_pkg::REM_W + 2)'({i_root, 2'b01});
        w_ge    = (w_acc >= w_trial);
        w_diff  = w_acc - w_trial;
        n_rem   = w_ge ? w_diff[gaq_pkg::REM_W-1:0] : w_acc[gaq_pkg::REM_W-1:0];
        n_root  = {i_root[gaq_pkg::ROOT_W-2:0], w_ge};
        n_rad   = {i_rad[gaq_pkg::RAD_W-3:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad  <= n_rad;
            r_rem  <= n_rem;
            r_root <= n_root;
        end
    end

    assign o_rad  = r_rad;
    assign o_rem  = r_rem;
    assign o_root = r_root;

endmodule

### src/gaq_div_cell.sv
// ----------------------------------------------------------------------------
// gaq_div_cell
// one quotient bit of a restoring divide for all lanes, shared divisor
// ----------------------------------------------------------------------------
module gaq_div_cell (
    input  logic                                            i_clk,
    input  logic                                            i_en,
    input  logic [gaq_pkg::DSH_W-1:0]                       i_dsh,
    input  logic [gaq_pkg::LANES-1:0][gaq_pkg::DREM_W-1:0]  i_rem,
    input  logic [gaq_pkg::LANES-1:0][gaq_pkg::QUO_W-1:0]   i_quo,
    output logic [gaq_pkg::DSH_W-1:0]                       o_dsh,
    output logic [gaq_pkg::LANES-1:0][gaq_pkg::DREM_W-1:0]  o_rem,
    output logic [gaq_pkg::LANES-1:0][gaq_pkg::QUO_W-1:0]   o_quo
);

    logic [gaq_pkg::DSH_W-1:0]                      r_dsh, n_dsh;
    logic [gaq_pkg::LANES-1:0][gaq_pkg::DREM_W-1:0] r_rem, n_rem;
    logic [gaq_pkg::LANES-1:0][gaq_pkg::QUO_W-1:0]  r_quo, n_quo;
    logic [gaq_pkg::DREM_W-1:0]                     w_dsh;
    logic [gaq_pkg::LANES-1:0]                      w_ge;

    always_comb begin
        w_dsh = gaq_pkg::DREM_W'(i_dsh);
        for (int l = 0; l < gaq_pkg::LANES; l++) begin
            w_ge[l]  = (i_rem[l] >= w_dsh);
            n_rem[l] = w_ge[l] ? (i_rem[l] - w_dsh) : i_rem[l];
            n_quo[l] = {i_quo[l][gaq_pkg::QUO_W-2:0], w_ge[l]};
        end
        n_dsh = i_dsh >> 1;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dsh <= n_dsh;
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_dsh = r_dsh;
    assign o_rem = r_rem;
    assign o_quo = r_quo;

endmodule

### src/gravity_align_quaternion_core.sv
// throughput: one sample per cycle; a stalled output freezes the whole pipeline
// the two square roots take one cell per root bit and the divide one cell per
// quotient bit, and these cell rows set the latency
// reset clears only the valid line; no state is carried between samples
// ----------------------------------------------------------------------------
// gravity_align_quaternion_core
// shortest-arc quaternion that turns an accelerometer sample onto -z
// ----------------------------------------------------------------------------
`include "gravity_align_quaternion_core_defines.svh"

module gravity_align_quaternion_core (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    output logic                                    o_stall,
    input  logic signed [gaq_pkg::SAMPLE_BITS-1:0]  i_accel_x,
    input  logic signed [gaq_pkg::SAMPLE_BITS-1:0]  i_accel_y,
    input  logic signed [gaq_pkg::SAMPLE_BITS-1:0]  i_accel_z,
    output logic                                    o_valid,
    input  logic                                    i_stall,
    output logic signed [gaq_pkg::QUAT_BITS-1:0]    o_quat_w,
    output logic signed [gaq_pkg::QUAT_BITS-1:0]    o_quat_x,
    output logic signed [gaq_pkg::QUAT_BITS-1:0]    o_quat_y,
    output logic                                    o_degenerate
);

    typedef struct packed {
        logic [gaq_pkg::PRE_BITS-1:0] mx;
        logic [gaq_pkg::PRE_BITS-1:0] my;
        logic [gaq_pkg::PRE_BITS-1:0] mz;
        logic                         sx;
        logic                         sy;
        logic                         sz;
        logic                         dg;
    } t_side1;

    typedef struct packed {
        logic [gaq_pkg::LANES-1:0][gaq_pkg::VEC_BITS-1:0] v;
        logic                                             sx;
        logic                                             sy;
        logic                                             dg;
    } t_side2;

    typedef struct packed {
        logic sx;
        logic sy;
        logic dg;
    } t_side3;

    function automatic logic [gaq_pkg::MAG_W-1:0] f_mag(input logic [gaq_pkg::MAG_W-1:0] v);
        return v[gaq_pkg::MAG_W-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic logic [gaq_pkg::BL1_W-1:0] f_bitlen1(
        input logic [gaq_pkg::MAG_W-1:0] v
    );
        logic [gaq_pkg::BL1_W-1:0] r;
        r = '0;
        for (int i = 0; i < gaq_pkg::MAG_W; i++) begin
            if (v[i]) r = gaq_pkg::BL1_W'(i + 1);
        end
        return r;
    endfunction

    function automatic logic [gaq_pkg::BL2_W-1:0] f_bitlen2(
        input logic [gaq_pkg::V_W-1:0] v
    );
        logic [gaq_pkg::BL2_W-1:0] r;
        r = '0;
        for (int i = 0; i < gaq_pkg::V_W; i++) begin
            if (v[i]) r = gaq_pkg::BL2_W'(i + 1);
        end
        return r;
    endfunction

    // (m << PRE) >> bitlen lands the leading one at the top of the window
    function automatic logic [gaq_pkg::PRE_BITS-1:0] f_pre(
        input logic [gaq_pkg::MAG_W-1:0] m,
        input logic [gaq_pkg::BL1_W-1:0] bl
    );
        logic [gaq_pkg::MAG_W+gaq_pkg::PRE_BITS-1:0] t;
        t = {m, {gaq_pkg::PRE_BITS{1'b0}}} >> bl;
        return t[gaq_pkg::PRE_BITS-1:0];
    endfunction

    function automatic logic [gaq_pkg::VEC_BITS-1:0] f_vec(
        input logic [gaq_pkg::V_W-1:0]   m,
        input logic [gaq_pkg::BL2_W-1:0] bl
    );
        logic [gaq_pkg::V_W+gaq_pkg::VEC_BITS-1:0] t;
        t = {m, {gaq_pkg::VEC_BITS{1'b0}}} >> bl;
        return t[gaq_pkg::VEC_BITS-1:0];
    endfunction

    logic                          w_en;
    logic [gaq_pkg::PIPE_LAT-1:0]  r_vld;

    assign w_en    = !(r_vld[gaq_pkg::PIPE_LAT-1] && i_stall);
    assign o_stall = !w_en;
    assign o_valid = r_vld[gaq_pkg::PIPE_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[gaq_pkg::PIPE_LAT-2:0], i_valid};
        end
    end

    // stage 1: sign and magnitude
    logic [gaq_pkg::MAG_W-1:0] r1_mx, r1_my, r1_mz;
    logic                      r1_sx, r1_sy, r1_sz;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_mx <= f_mag(i_accel_x);
            r1_my <= f_mag(i_accel_y);
            r1_mz <= f_mag(i_accel_z);
            r1_sx <= i_accel_x[gaq_pkg::MAG_W-1];
            r1_sy <= i_accel_y[gaq_pkg::MAG_W-1];
            r1_sz <= i_accel_z[gaq_pkg::MAG_W-1];
        end
    end

    // stage 2: bit length of the largest magnitude
    logic [gaq_pkg::MAG_W-1:0] w2_mxy, w2_max;
    logic [gaq_pkg::MAG_W-1:0] r2_mx, r2_my, r2_mz;
    logic                      r2_sx, r2_sy, r2_sz;
    logic [gaq_pkg::BL1_W-1:0] r2_bl;

    assign w2_mxy = (r1_mx > r1_my) ? r1_mx : r1_my;
    assign w2_max = (w2_mxy > r1_mz) ? w2_mxy : r1_mz;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_mx <= r1_mx;
            r2_my <= r1_my;
            r2_mz <= r1_mz;
            r2_sx <= r1_sx;
            r2_sy <= r1_sy;
            r2_sz <= r1_sz;
            r2_bl <= f_bitlen1(w2_max);
        end
    end

    // stage 3: scale to the fixed window
    t_side1 r3_sd;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_sd.mx <= f_pre(r2_mx, r2_bl);
            r3_sd.my <= f_pre(r2_my, r2_bl);
            r3_sd.mz <= f_pre(r2_mz, r2_bl);
            r3_sd.sx <= r2_sx;
            r3_sd.sy <= r2_sy;
            r3_sd.sz <= r2_sz;
            r3_sd.dg <= (r2_bl == '0);
        end
    end

    // stage 4: squares
    logic [gaq_pkg::SQR1_W-1:0] r4_qx, r4_qy, r4_qz;
    t_side1                     r4_sd;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_qx <= gaq_pkg::SQR1_W'(r3_sd.mx) * gaq_pkg::SQR1_W'(r3_sd.mx);
            r4_qy <= gaq_pkg::SQR1_W'(r3_sd.my) * gaq_pkg::SQR1_W'(r3_sd.my);
            r4_qz <= gaq_pkg::SQR1_W'(r3_sd.mz) * gaq_pkg::SQR1_W'(r3_sd.mz);
            r4_sd <= r3_sd;
        end
    end

    // stage 5: sum of squares, moved up for the fractional root bits
    logic [gaq_pkg::SUM1_W-1:0] w5_n;
    logic [gaq_pkg::RAD_W-1:0]  r5_rad;
    t_side1                     r5_sd;

    assign w5_n = gaq_pkg::SUM1_W'(r4_qx) + gaq_pkg::SUM1_W'(r4_qy)
                + gaq_pkg::SUM1_W'(r4_qz);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_rad <= gaq_pkg::RAD_W'({w5_n, {(2 * gaq_pkg::N_FRAC){1'b0}}});
            r5_sd  <= r4_sd;
        end
    end

    // first root: norm of the sample
    logic [gaq_pkg::RAD_W-1:0]  w_rad1  [gaq_pkg::SQ_STEPS+1];
    logic [gaq_pkg::REM_W-1:0]  w_rem1  [gaq_pkg::SQ_STEPS+1];
    logic [gaq_pkg::ROOT_W-1:0] w_root1 [gaq_pkg::SQ_STEPS+1];
    t_side1                     r_sd1   [gaq_pkg::SQ_STEPS];

    assign w_rad1[0]  = r5_rad;
    assign w_rem1[0]  = '0;
    assign w_root1[0] = '0;

    for (genvar g = 0; g < gaq_pkg::SQ_STEPS; g++) begin : g_sqrt1
        gaq_sqrt_cell u_cell (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_rad  (w_rad1[g]),
            .i_rem  (w_rem1[g]),
            .i_root (w_root1[g]),
            .o_rad  (w_rad1[g+1]),
            .o_rem  (w_rem1[g+1]),
            .o_root (w_root1[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sd1[0] <= r5_sd;
            for (int i = 1; i < gaq_pkg::SQ_STEPS; i++) begin
                r_sd1[i] <= r_sd1[i-1];
            end
        end
    end

    // stage 6: rotation vector (n - az, -ay, ax) in magnitudes
    t_side1                  w6_sd;
    logic [gaq_pkg::V_W-1:0] w6_nf, w6_zf;
    logic [gaq_pkg::V_W-1:0] r6_vw, r6_vx, r6_vy;
    logic                    r6_sx, r6_sy, r6_dg;

    assign w6_sd = r_sd1[gaq_pkg::SQ_STEPS-1];
    assign w6_nf = gaq_pkg::V_W'(w_root1[gaq_pkg::SQ_STEPS]);
    assign w6_zf = gaq_pkg::V_W'({w6_sd.mz, {gaq_pkg::N_FRAC{1'b0}}});

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_vw <= w6_sd.sz ? (w6_nf + w6_zf) : (w6_nf - w6_zf);
            r6_vx <= gaq_pkg::V_W'({w6_sd.my, {gaq_pkg::N_FRAC{1'b0}}});
            r6_vy <= gaq_pkg::V_W'({w6_sd.mx, {gaq_pkg::N_FRAC{1'b0}}});
            r6_sx <= w6_sd.sx;
            r6_sy <= w6_sd.sy;
            r6_dg <= w6_sd.dg;
        end
    end

    // stage 7: bit length of the largest vector entry
    logic [gaq_pkg::V_W-1:0]   w7_mwx, w7_max;
    logic [gaq_pkg::V_W-1:0]   r7_vw, r7_vx, r7_vy;
    logic                      r7_sx, r7_sy, r7_dg;
    logic [gaq_pkg::BL2_W-1:0] r7_bl;

    assign w7_mwx = (r6_vw > r6_vx) ? r6_vw : r6_vx;
    assign w7_max = (w7_mwx > r6_vy) ? w7_mwx : r6_vy;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r7_vw <= r6_vw;
            r7_vx <= r6_vx;
            r7_vy <= r6_vy;
            r7_sx <= r6_sx;
            r7_sy <= r6_sy;
            r7_dg <= r6_dg;
            r7_bl <= f_bitlen2(w7_max);
        end
    end

    // stage 8: scale the vector
    t_side2 r8_sd;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r8_sd.v[0] <= f_vec(r7_vw, r7_bl);
            r8_sd.v[1] <= f_vec(r7_vx, r7_bl);
            r8_sd.v[2] <= f_vec(r7_vy, r7_bl);
            r8_sd.sx   <= r7_sx;
            r8_sd.sy   <= r7_sy;
            r8_sd.dg   <= r7_dg || (r7_bl == '0);
        end
    end

    // stage 9: squares of the vector
    logic [gaq_pkg::LANES-1:0][gaq_pkg::SQR2_W-1:0] r9_q;
    t_side2                                         r9_sd;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int l = 0; l < gaq_pkg::LANES; l++) begin
                r9_q[l] <= gaq_pkg::SQR2_W'(r8_sd.v[l]) * gaq_pkg::SQR2_W'(r8_sd.v[l]);
            end
            r9_sd <= r8_sd;
        end
    end

    // stage 10: sum of squares
    logic [gaq_pkg::SUM2_W-1:0] w10_s;
    logic [gaq_pkg::RAD_W-1:0]  r10_rad;
    t_side2                     r10_sd;

    assign w10_s = gaq_pkg::SUM2_W'(r9_q[0]) + gaq_pkg::SUM2_W'(r9_q[1])
                 + gaq_pkg::SUM2_W'(r9_q[2]);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r10_rad <= gaq_pkg::RAD_W'(w10_s);
            r10_sd  <= r9_sd;
        end
    end

    // second root: vector length
    logic [gaq_pkg::RAD_W-1:0]  w_rad2  [gaq_pkg::SQ_STEPS+1];
    logic [gaq_pkg::REM_W-1:0]  w_rem2  [gaq_pkg::SQ_STEPS+1];
    logic [gaq_pkg::ROOT_W-1:0] w_root2 [gaq_pkg::SQ_STEPS+1];
    t_side2                     r_sd2   [gaq_pkg::SQ_STEPS];

    assign w_rad2[0]  = r10_rad;
    assign w_rem2[0]  = '0;
    assign w_root2[0] = '0;

    for (genvar g = 0; g < gaq_pkg::SQ_STEPS; g++) begin : g_sqrt2
        gaq_sqrt_cell u_cell (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_rad  (w_rad2[g]),
            .i_rem  (w_rem2[g]),
            .i_root (w_root2[g]),
            .o_rad  (w_rad2[g+1]),
            .o_rem  (w_rem2[g+1]),
            .o_root (w_root2[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sd2[0] <= r10_sd;
            for (int i = 1; i < gaq_pkg::SQ_STEPS; i++) begin
                r_sd2[i] <= r_sd2[i-1];
            end
        end
    end

    // stage 11: divide setup, numerator carries half the divisor for rounding
    t_side2                                         w11_sd;
    logic [gaq_pkg::ROOT_W-1:0]                     w11_d;
    logic [gaq_pkg::DSH_W-1:0]                      r11_dsh;
    logic [gaq_pkg::LANES-1:0][gaq_pkg::DREM_W-1:0] r11_rem;
    t_side3                                         r11_sd;

    assign w11_sd = r_sd2[gaq_pkg::SQ_STEPS-1];
    assign w11_d  = w_root2[gaq_pkg::SQ_STEPS];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r11_dsh <= {w11_d, {gaq_pkg::QUAT_FRAC_BITS{1'b0}}};
            for (int l = 0; l < gaq_pkg::LANES; l++) begin
                r11_rem[l] <= gaq_pkg::DREM_W'({w11_sd.v[l], {gaq_pkg::QUAT_FRAC_BITS{1'b0}}})
                            + gaq_pkg::DREM_W'(w11_d >> 1);
            end
            r11_sd.sx <= w11_sd.sx;
            r11_sd.sy <= w11_sd.sy;
            r11_sd.dg <= w11_sd.dg || (w11_d == '0);
        end
    end

    // divide row
    logic [gaq_pkg::DSH_W-1:0]                      w_dsh [gaq_pkg::DIV_STEPS+1];
    logic [gaq_pkg::LANES-1:0][gaq_pkg::DREM_W-1:0] w_drem [gaq_pkg::DIV_STEPS+1];
    logic [gaq_pkg::LANES-1:0][gaq_pkg::QUO_W-1:0]  w_quo [gaq_pkg::DIV_STEPS+1];
    t_side3                                         r_sd3 [gaq_pkg::DIV_STEPS];

    assign w_dsh[0]  = r11_dsh;
    assign w_drem[0] = r11_rem;
    assign w_quo[0]  = '0;

    for (genvar g = 0; g < gaq_pkg::DIV_STEPS; g++) begin : g_div
        gaq_div_cell u_cell (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_dsh (w_dsh[g]),
            .i_rem (w_drem[g]),
            .i_quo (w_quo[g]),
            .o_dsh (w_dsh[g+1]),
            .o_rem (w_drem[g+1]),
            .o_quo (w_quo[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sd3[0] <= r11_sd;
            for (int i = 1; i < gaq_pkg::DIV_STEPS; i++) begin
                r_sd3[i] <= r_sd3[i-1];
            end
        end
    end

    // stage 12: saturate, apply signs, output register
    t_side3                                           w12_sd;
    logic [gaq_pkg::LANES-1:0][gaq_pkg::QUAT_BITS-1:0] w12_q;
    logic signed [gaq_pkg::QUAT_BITS-1:0]             r_qw, r_qx, r_qy;
    logic                                             r_dg;

    assign w12_sd = r_sd3[gaq_pkg::DIV_STEPS-1];

    always_comb begin
        for (int l = 0; l < gaq_pkg::LANES; l++) begin
            w12_q[l] = gaq_pkg::QUAT_BITS'(w_quo[gaq_pkg::DIV_STEPS][l]);
            if (w12_q[l] > gaq_pkg::QUAT_ONE) w12_q[l] = gaq_pkg::QUAT_ONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (w12_sd.dg) begin
                r_qw <= gaq_pkg::QUAT_ONE;
                r_qx <= '0;
                r_qy <= '0;
            end else begin
                r_qw <= w12_q[0];
                // x follows -ay, y follows ax
                r_qx <= w12_sd.sy ? w12_q[1] : (~w12_q[1] + 1'b1);
                r_qy <= w12_sd.sx ? (~w12_q[2] + 1'b1) : w12_q[2];
            end
            r_dg <= w12_sd.dg;
        end
    end

    assign o_quat_w     = r_qw;
    assign o_quat_x     = r_qx;
    assign o_quat_y     = r_qy;
    assign o_degenerate = r_dg;

    `GAQ_ASSERT_IMP(a_degen_identity, i_clk, i_rst_n, o_valid && o_degenerate, o_quat_w == gaq_pkg::QUAT_ONE && o_quat_x == '0 && o_quat_y == '0)
    `GAQ_ASSERT_IMP(a_w_not_negative, i_clk, i_rst_n, o_valid, !o_quat_w[gaq_pkg::QUAT_BITS-1])
    `GAQ_ASSERT_IMP(a_xy_in_range, i_clk, i_rst_n, o_valid, o_quat_x <= gaq_pkg::QUAT_ONE && o_quat_x >= -gaq_pkg::QUAT_ONE && o_quat_y <= gaq_pkg::QUAT_ONE && o_quat_y >= -gaq_pkg::QUAT_ONE)
    `GAQ_ASSERT_NXT(a_accept_enters, i_clk, i_rst_n, i_valid && !o_stall, r_vld[0])

endmodule
